>>> sv/rclfp_pkg.sv
// Shared types and constants of the RC link frame parser.
package rclfp_pkg;

  localparam int FRAME_BUFFER_DEPTH_DEF = 64;

  localparam logic [7:0] SYNC_RESET    = 8'd200;
  localparam logic [7:0] CH_TYPE_RESET = 8'd22;
  localparam logic [7:0] LS_TYPE_RESET = 8'd20;

  localparam logic [7:0] CRC_POLY = 8'hD5;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CH_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LS_TYPE = 2'd2;

  localparam logic [1:0] KIND_CHAN = 2'd0;
  localparam logic [1:0] KIND_LS   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int VALUE_W     = 13;
  localparam int INDEX_W     = 4;

  localparam int MIN_TRIG_POS  = 5;
  localparam int PAYLOAD_START = 3;
  localparam int CH_BITS       = 11;
  localparam int CH_CENTER     = 992;
  localparam int US_CENTER     = 1500;
  localparam logic [INDEX_W-1:0] LAST_CH    = 4'd15;
  localparam logic [INDEX_W-1:0] LAST_LS    = 4'd9;
  localparam logic [INDEX_W-1:0] SNR_UL_IDX = 4'd3;
  localparam logic [INDEX_W-1:0] SNR_DL_IDX = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_ERR,
    ST_RD,
    ST_LOAD,
    ST_SHIFT,
    ST_CH_EMIT,
    ST_LS_EMIT
  } st_t;

endpackage

>>> sv/rclfp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rclfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rclfp_pkg::FRAME_BUFFER_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/rc_link_frame_parser.sv
// RC link frame parser: sync search, frame store, bit-serial CRC-8 and decode.
//
// Usage: received serial bytes enter one word at a time on in_* (tdata = rx_byte).
// Bytes are dropped until the sync byte; the frame is then written to the
// frame buffer. When the position reaches length+2 the CRC-8 (poly 0xD5) over
// type and payload is checked. A good channel frame gives sixteen results, a
// good link statistics frame ten, a bad CRC one error result; out_tlast marks
// the final result of a frame. cfg_* writes sync/type registers (index 0..2).
// Flow: a dropped byte, the sync and length bytes and the byte that closes a
// frame are only accepted; every other stored byte is accepted and then run
// through the bit-serial CRC register before the next byte is taken. At frame
// end a bad CRC passes the error state, which writes the error result once the
// output register is free; a link statistics frame runs buffer read, load and
// emit per field; a channel frame takes 22 buffer reads, each feeding its bits
// one at a time into the 11-bit channel register, plus one emit per channel.
// The bit-serial shifter and the single buffer read port set this pace.
// Reset clears the write position and output valid and loads default codes.
// A stalled receiver holds the output register; decoding waits for it, and a
// new byte is taken once the last result of the frame sits in that register.
module rc_link_frame_parser #(
  parameter int FRAME_BUFFER_DEPTH = rclfp_pkg::FRAME_BUFFER_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [7:0] rx_byte
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rclfp_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: [1:0] kind, [5:2] field_index, [18:6] value, [23:19] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rclfp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rclfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                          cfg_data
);

  localparam int PW = $clog2(FRAME_BUFFER_DEPTH);
  localparam logic [PW:0]   DEPTH_W   = (PW+1)'(FRAME_BUFFER_DEPTH);
  localparam logic [PW-1:0] ADDR_LAST = PW'(FRAME_BUFFER_DEPTH - 1);
  localparam logic [PW-1:0] PAY_START = PW'(rclfp_pkg::PAYLOAD_START);
  localparam logic [3:0]    CH_LAST_BIT = 4'(rclfp_pkg::CH_BITS - 1);

  rclfp_pkg::st_t state_r, state_nxt;

  logic [7:0]    sync_r, ch_type_r, ls_type_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    store0_r, store0_nxt, len_r, len_nxt, type_r, type_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic [3:0]    bit_cnt_r, bit_cnt_nxt;
  logic [3:0]    chan_bits_r, chan_bits_nxt;
  logic [10:0]   chan_sr_r, chan_sr_nxt;
  logic [7:0]    byte_sr_r, byte_sr_nxt;
  logic [3:0]    res_cnt_r, res_cnt_nxt;
  logic          mode_ch_r, mode_ch_nxt;
  logic [PW-1:0] rd_addr_r, rd_addr_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_kind_r, out_kind_nxt;
  logic [3:0]                    out_idx_r, out_idx_nxt;
  logic [rclfp_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [7:0]    rx_byte;
  logic          acc, drop, trig, crc_ok, slot_free;
  logic [PW:0]   pos_inc;
  logic [PW-1:0] pos_adv;
  logic [8:0]    pos_ext;
  logic [7:0]    ram_rdata;

  logic [13:0]        t5;
  logic signed [14:0] x, x_adj, q;
  logic [rclfp_pkg::VALUE_W-1:0] ch_value, ls_value;

  assign rx_byte   = in_tdata[7:0];
  assign in_tready = (state_r == rclfp_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = in_tvalid & in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign drop    = (pos_r == '0) && (rx_byte != sync_r);
  assign pos_inc = {1'b0, pos_r} + (PW+1)'(1);
  assign pos_adv = (pos_inc == DEPTH_W) ? '0 : pos_inc[PW-1:0];
  assign pos_ext = 9'(pos_adv);
  // length byte of this frame: the stored len_r, written from an earlier byte
  assign trig    = (pos_ext > 9'(rclfp_pkg::MIN_TRIG_POS)) && (store0_r == sync_r) &&
                   (pos_ext == {1'b0, len_r} + 9'd2);
  assign crc_ok  = (crc_r == rx_byte);

  // (t - 992) * 5 / 8 + 1500, quotient truncated toward zero
  assign t5    = {1'b0, chan_sr_r, 2'b00} + {3'b000, chan_sr_r};
  assign x     = $signed({1'b0, t5}) - 15'sd4960;
  assign x_adj = x[14] ? x + 15'sd7 : x;
  assign q     = x_adj >>> 3;
  assign ch_value = rclfp_pkg::VALUE_W'(q + 15'sd1500);

  assign ls_value = ((res_cnt_r == rclfp_pkg::SNR_UL_IDX) ||
                     (res_cnt_r == rclfp_pkg::SNR_DL_IDX)) ?
                    {{5{byte_sr_r[7]}}, byte_sr_r} : {5'b00000, byte_sr_r};

  rclfp_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (acc && !drop),
    .waddr (pos_r),
    .wdata (rx_byte),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rclfp_pkg::ST_IDLE: begin
        if (acc && !drop) begin
          if (trig) begin
            if (!crc_ok) begin
              state_nxt = rclfp_pkg::ST_ERR;
            end else if ((type_r == ch_type_r) || (type_r == ls_type_r)) begin
              state_nxt = rclfp_pkg::ST_RD;
            end
          end else if (pos_r > PW'(1)) begin
            state_nxt = rclfp_pkg::ST_CRC;
          end
        end
      end
      rclfp_pkg::ST_CRC: begin
        if (bit_cnt_r == 4'd1) state_nxt = rclfp_pkg::ST_IDLE;
      end
      rclfp_pkg::ST_ERR: begin
        if (slot_free) state_nxt = rclfp_pkg::ST_IDLE;
      end
      rclfp_pkg::ST_RD:   state_nxt = rclfp_pkg::ST_LOAD;
      rclfp_pkg::ST_LOAD: state_nxt = mode_ch_r ? rclfp_pkg::ST_SHIFT : rclfp_pkg::ST_LS_EMIT;
      rclfp_pkg::ST_SHIFT: begin
        if (chan_bits_r == CH_LAST_BIT) begin
          state_nxt = rclfp_pkg::ST_CH_EMIT;
        end else if (bit_cnt_r == 4'd1) begin
          state_nxt = rclfp_pkg::ST_RD;
        end
      end
      rclfp_pkg::ST_CH_EMIT: begin
        if (slot_free) begin
          if (res_cnt_r == rclfp_pkg::LAST_CH) begin
            state_nxt = rclfp_pkg::ST_IDLE;
          end else if (bit_cnt_r == 4'd0) begin
            state_nxt = rclfp_pkg::ST_RD;
          end else begin
            state_nxt = rclfp_pkg::ST_SHIFT;
          end
        end
      end
      rclfp_pkg::ST_LS_EMIT: begin
        if (slot_free) begin
          state_nxt = (res_cnt_r == rclfp_pkg::LAST_LS) ? rclfp_pkg::ST_IDLE : rclfp_pkg::ST_RD;
        end
      end
      default: state_nxt = rclfp_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pos_nxt       = pos_r;
    store0_nxt    = store0_r;
    len_nxt       = len_r;
    type_nxt      = type_r;
    crc_nxt       = crc_r;
    bit_cnt_nxt   = bit_cnt_r;
    chan_bits_nxt = chan_bits_r;
    chan_sr_nxt   = chan_sr_r;
    byte_sr_nxt   = byte_sr_r;
    res_cnt_nxt   = res_cnt_r;
    mode_ch_nxt   = mode_ch_r;
    rd_addr_nxt   = rd_addr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      rclfp_pkg::ST_IDLE: begin
        if (acc && !drop) begin
          pos_nxt = trig ? '0 : pos_adv;
          if (pos_r == '0)    store0_nxt = rx_byte;
          if (pos_r == PW'(1)) len_nxt   = rx_byte;
          if (pos_r == PW'(2)) type_nxt  = rx_byte;
          // crc covers bytes from the type byte on
          crc_nxt     = (pos_r == '0) ? 8'h00 : (pos_r > PW'(1)) ? crc_r ^ rx_byte : crc_r;
          bit_cnt_nxt = 4'd8;
          if (trig) begin
            chan_bits_nxt = '0;
            res_cnt_nxt   = '0;
            rd_addr_nxt   = PAY_START;
            mode_ch_nxt   = (type_r == ch_type_r);
          end
        end
      end
      rclfp_pkg::ST_CRC: begin
        crc_nxt     = crc_r[7] ? ({crc_r[6:0], 1'b0} ^ rclfp_pkg::CRC_POLY) : {crc_r[6:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 4'd1;
      end
      rclfp_pkg::ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = rclfp_pkg::KIND_ERR;
          out_idx_nxt   = '0;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
        end
      end
      rclfp_pkg::ST_LOAD: begin
        byte_sr_nxt = ram_rdata;
        bit_cnt_nxt = 4'd8;
        rd_addr_nxt = (rd_addr_r == ADDR_LAST) ? '0 : rd_addr_r + PW'(1);
      end
      rclfp_pkg::ST_SHIFT: begin
        chan_sr_nxt   = {byte_sr_r[0], chan_sr_r[10:1]};
        byte_sr_nxt   = {1'b0, byte_sr_r[7:1]};
        bit_cnt_nxt   = bit_cnt_r - 4'd1;
        chan_bits_nxt = chan_bits_r + 4'd1;
      end
      rclfp_pkg::ST_CH_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = rclfp_pkg::KIND_CHAN;
          out_idx_nxt   = res_cnt_r;
          out_value_nxt = ch_value;
          out_last_nxt  = (res_cnt_r == rclfp_pkg::LAST_CH);
          res_cnt_nxt   = res_cnt_r + 4'd1;
          chan_bits_nxt = '0;
        end
      end
      rclfp_pkg::ST_LS_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = rclfp_pkg::KIND_LS;
          out_idx_nxt   = res_cnt_r;
          out_value_nxt = ls_value;
          out_last_nxt  = (res_cnt_r == rclfp_pkg::LAST_LS);
          res_cnt_nxt   = res_cnt_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rclfp_pkg::ST_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      sync_r      <= rclfp_pkg::SYNC_RESET;
      ch_type_r   <= rclfp_pkg::CH_TYPE_RESET;
      ls_type_r   <= rclfp_pkg::LS_TYPE_RESET;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rclfp_pkg::CFG_SYNC:    sync_r    <= cfg_data;
          rclfp_pkg::CFG_CH_TYPE: ch_type_r <= cfg_data;
          rclfp_pkg::CFG_LS_TYPE: ls_type_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    store0_r    <= store0_nxt;
    len_r       <= len_nxt;
    type_r      <= type_nxt;
    crc_r       <= crc_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    chan_bits_r <= chan_bits_nxt;
    chan_sr_r   <= chan_sr_nxt;
    byte_sr_r   <= byte_sr_nxt;
    res_cnt_r   <= res_cnt_nxt;
    mode_ch_r   <= mode_ch_nxt;
    rd_addr_r   <= rd_addr_nxt;
    out_kind_r  <= out_kind_nxt;
    out_idx_r   <= out_idx_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_value_r, out_idx_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule

>>> sv/rclfp_checker.sv
// Port-level checker for the RC link frame parser, bound to the top level.
module rclfp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [rclfp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [rclfp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tlast,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [rclfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [7:0]                        cfg_data
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == rclfp_pkg::KIND_ERR) |->
      out_tlast && (out_tdata[18:2] == '0))
    else $error("malformed CRC error word");

  // no new byte is taken while a result other than the last of its frame is held
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a frame's results");

  a_chan_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == rclfp_pkg::KIND_CHAN) |->
      (out_tlast == (out_tdata[5:2] == rclfp_pkg::LAST_CH)))
    else $error("channel word with wrong last flag");

  a_ls_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == rclfp_pkg::KIND_LS) |->
      (out_tdata[5:2] <= rclfp_pkg::LAST_LS) &&
      (out_tlast == (out_tdata[5:2] == rclfp_pkg::LAST_LS)))
    else $error("link statistics word out of range or wrong last flag");

endmodule

bind rc_link_frame_parser rclfp_checker u_rclfp_checker (.*);

>>> bench/tb_rc_link_frame_parser.sv
// Self-checking testbench for rc_link_frame_parser: frame stimulus, decode prediction, checks.
module tb_rc_link_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = rclfp_pkg::FRAME_BUFFER_DEPTH_DEF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  fidx;
    logic [12:0] value;
    logic        is_last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [rclfp_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [rclfp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                              out_tlast;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [rclfp_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [7:0]                        cfg_data = '0;

  rc_link_frame_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser state as the bench sees it
  logic [7:0] frame_mem [DEPTH];
  int         wr_pos = 0;
  logic [7:0] sync_reg = rclfp_pkg::SYNC_RESET;
  logic [7:0] ch_type_reg = rclfp_pkg::CH_TYPE_RESET;
  logic [7:0] ls_type_reg = rclfp_pkg::LS_TYPE_RESET;

  logic [7:0] byte_stream [$];
  result_t    frame_results [$];
  int         err_cnt = 0;

  bit in_fire = 1'b0;
  int src_gap = 0;
  int src_quiet = 0;
  int sink_stall = 0;
  int sink_quiet = 0;

  function automatic logic [7:0] crc_d5_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++)
      c = c[7] ? ((c << 1) ^ rclfp_pkg::CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic void add_result(input logic [1:0] kind, input logic [3:0] fidx,
                                     input logic [12:0] value, input logic is_last);
    result_t r;
    r.kind = kind;
    r.fidx = fidx;
    r.value = value;
    r.is_last = is_last;
    frame_results.push_back(r);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    int         len;
    int         off;
    int         base;
    int         t;
    int         us;
    logic [7:0] crc;
    logic [7:0] stat;
    logic [23:0] w;
    if (wr_pos == 0 && b != sync_reg) return;
    frame_mem[wr_pos] = b;
    wr_pos = (wr_pos + 1) % DEPTH;
    if (wr_pos <= rclfp_pkg::MIN_TRIG_POS) return;
    if (frame_mem[0] != sync_reg) return;
    len = frame_mem[1];
    if (len + 2 != wr_pos) return;
    crc = 8'h00;
    for (int i = 2; i <= len; i++)
      crc = crc_d5_next(crc, frame_mem[i % DEPTH]);
    wr_pos = 0;
    if (crc != frame_mem[(len + 1) % DEPTH]) begin
      add_result(rclfp_pkg::KIND_ERR, '0, '0, 1'b1);
      return;
    end
    // equal type codes decode as channels only
    if (frame_mem[2] == ch_type_reg) begin
      for (int ch = 0; ch < 16; ch++) begin
        off = ch * rclfp_pkg::CH_BITS;
        base = rclfp_pkg::PAYLOAD_START + off / 8;
        w = {frame_mem[(base + 2) % DEPTH], frame_mem[(base + 1) % DEPTH],
             frame_mem[base % DEPTH]};
        t = int'((w >> (off % 8)) & 24'h7FF);
        us = (t - rclfp_pkg::CH_CENTER) * 5 / 8 + rclfp_pkg::US_CENTER;
        add_result(rclfp_pkg::KIND_CHAN, 4'(ch), us[12:0], ch == rclfp_pkg::LAST_CH);
      end
    end else if (frame_mem[2] == ls_type_reg) begin
      for (int f = 0; f < 10; f++) begin
        stat = frame_mem[(rclfp_pkg::PAYLOAD_START + f) % DEPTH];
        if (f == rclfp_pkg::SNR_UL_IDX || f == rclfp_pkg::SNR_DL_IDX)
          add_result(rclfp_pkg::KIND_LS, 4'(f), {{5{stat[7]}}, stat},
                     f == rclfp_pkg::LAST_LS);
        else
          add_result(rclfp_pkg::KIND_LS, 4'(f), {5'b0, stat}, f == rclfp_pkg::LAST_LS);
      end
    end
  endfunction

  // mostly short gaps, a few long ones, now and then a quiet stretch
  function automatic int pick_idle(ref int quiet_left);
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // input side: acceptance and prediction
  always @(posedge clk) begin
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) parse_byte(in_tdata);
  end

  // byte driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (src_gap > 0) begin
        src_gap--;
        in_tvalid <= 1'b0;
      end else if (byte_stream.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= byte_stream.pop_front();
        src_gap = pick_idle(src_quiet);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      sink_stall = pick_idle(sink_quiet);
    end
  end

  // result monitor
  always @(posedge clk) begin : mon
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_results.size() == 0) begin
        $error("result word with nothing expected: tdata=%h tlast=%b", out_tdata, out_tlast);
        err_cnt++;
      end else begin
        want = frame_results.pop_front();
        check_field("kind", want.kind, out_tdata[1:0]);
        check_field("field_index", want.fidx, out_tdata[5:2]);
        check_field("value", $signed(want.value), $signed(out_tdata[18:6]));
        check_field("pad", 0, out_tdata[23:19]);
        check_field("last", want.is_last, out_tlast);
      end
    end
  end

  task automatic write_reg(input logic [rclfp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rclfp_pkg::CFG_SYNC:    sync_reg = val;
      rclfp_pkg::CFG_CH_TYPE: ch_type_reg = val;
      rclfp_pkg::CFG_LS_TYPE: ls_type_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (byte_stream.size() != 0 || in_tvalid || frame_results.size() != 0)
      @(posedge clk);
    // a trailing byte may cause no result but still run through the CRC shifter
    repeat (40) @(posedge clk);
  endtask

  // fill < 0 gives random payload; keep > 0 cuts the frame after that many bytes
  task automatic push_frame(input logic [7:0] ftype, input int len, input int fill,
                            input bit bad_crc, input int keep);
    logic [7:0] fb [$];
    logic [7:0] crc;
    logic [7:0] pb;
    int         n;
    fb.push_back(sync_reg);
    fb.push_back(8'(len));
    fb.push_back(ftype);
    crc = crc_d5_next(8'h00, ftype);
    for (int i = 3; i <= len; i++) begin
      pb = (fill < 0) ? 8'($urandom) : 8'(fill);
      fb.push_back(pb);
      crc = crc_d5_next(crc, pb);
    end
    if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
    fb.push_back(crc);
    n = (keep <= 0 || keep > fb.size()) ? fb.size() : keep;
    for (int i = 0; i < n; i++) byte_stream.push_back(fb[i]);
  endtask

  // length that never matches: the position runs to the end of the buffer and wraps
  task automatic push_wrap(input logic [7:0] len);
    byte_stream.push_back(sync_reg);
    byte_stream.push_back(len);
    repeat (DEPTH - 2) byte_stream.push_back(8'($urandom));
  endtask

  task automatic push_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom); while (b == sync_reg);
      byte_stream.push_back(b);
    end
  endtask

  task automatic random_traffic(input int n_bytes);
    int         sent;
    int         start_size;
    int         r;
    int         len;
    logic [7:0] ft;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 5) == 0) push_noise($urandom_range(1, 3));
      start_size = byte_stream.size();
      r = $urandom_range(0, 99);
      if (r < 38) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 61) : 24;
        push_frame(ch_type_reg, len, -1, 1'b0, 0);
      end else if (r < 62) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 61) : 12;
        push_frame(ls_type_reg, len, -1, 1'b0, 0);
      end else if (r < 72) begin
        push_frame(8'($urandom), $urandom_range(4, 20), -1, 1'b0, 0);
      end else if (r < 82) begin
        ft = r[0] ? ch_type_reg : ls_type_reg;
        push_frame(ft, r[0] ? 24 : 12, -1, 1'b1, 0);
      end else if (r < 92) begin
        push_frame(ch_type_reg, 24, -1, 1'b0, $urandom_range(2, 20));
      end else if (r < 97) begin
        push_noise($urandom_range(1, 4));
      end else begin
        push_wrap(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                              : 8'($urandom_range(62, 255)));
      end
      sent += byte_stream.size() - start_size;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset codes; write every buffer entry first so no decode reads an unset one
    push_wrap(8'hFF);
    byte_stream.push_back(8'h00);
    byte_stream.push_back(8'hFF);
    push_frame(ch_type_reg, 24, 8'h00, 1'b0, 0);
    push_frame(ch_type_reg, 24, 8'hFF, 1'b0, 0);
    push_frame(ls_type_reg, 12, 8'h80, 1'b0, 0);
    push_frame(ch_type_reg, 24, -1, 1'b1, 0);
    push_frame(8'h00, 6, -1, 1'b0, 0);
    push_frame(ch_type_reg, 4, -1, 1'b0, 0);
    push_frame(ls_type_reg, 61, -1, 1'b0, 0);
    wait_idle();

    write_reg(rclfp_pkg::CFG_SYNC, 8'h00);
    write_reg(rclfp_pkg::CFG_CH_TYPE, 8'hFF);
    write_reg(rclfp_pkg::CFG_LS_TYPE, 8'h00);
    push_frame(ch_type_reg, 24, -1, 1'b0, 0);
    push_frame(ls_type_reg, 12, -1, 1'b0, 0);
    random_traffic(4);
    wait_idle();

    // shared type code
    write_reg(rclfp_pkg::CFG_SYNC, 8'hFF);
    write_reg(rclfp_pkg::CFG_CH_TYPE, 8'h5A);
    write_reg(rclfp_pkg::CFG_LS_TYPE, 8'h5A);
    push_frame(8'h5A, 12, -1, 1'b0, 0);
    push_frame(8'h5A, 24, -1, 1'b0, 0);
    random_traffic(4);
    wait_idle();

    write_reg(rclfp_pkg::CFG_SYNC, 8'($urandom));
    write_reg(rclfp_pkg::CFG_CH_TYPE, 8'($urandom));
    write_reg(rclfp_pkg::CFG_LS_TYPE, 8'($urandom));
    random_traffic(4);
    wait_idle();

    write_reg(rclfp_pkg::CFG_LS_TYPE, rclfp_pkg::LS_TYPE_RESET);
    write_reg(rclfp_pkg::CFG_CH_TYPE, rclfp_pkg::CH_TYPE_RESET);
    write_reg(rclfp_pkg::CFG_SYNC, rclfp_pkg::SYNC_RESET);
    random_traffic(4);
    wait_idle();

    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #100ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
